>>> design/btr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bearing triangulation ranger package
// Shared types, field widths and the elaboration-time trigonometric tables.
// ----------------------------------------------------------------------------
package btr_pkg;

    localparam int BTR_DIST_BITS       = 16;
    localparam int BTR_FRAC_BITS       = 8;
    localparam int BTR_TABLE_FRAC_BITS = 18;
    localparam int BTR_RANGE_BITS      = 30;

    localparam logic [63:0] BTR_PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        BTR_OK   = 2'd0,
        BTR_SAME = 2'd1,
        BTR_WIDE = 2'd2,
        BTR_GEOM = 2'd3
    } btr_status_t;

    typedef struct packed {
        logic                     cmd;
        logic [8:0]               bearing_one;
        logic [8:0]               bearing_two;
        logic [BTR_DIST_BITS-1:0] baseline_distance;
        logic [8:0]               baseline_bearing;
    } btr_request_t;

    typedef struct packed {
        logic [BTR_RANGE_BITS-1:0] range_from_first;
        logic [BTR_RANGE_BITS-1:0] range_from_second;
        logic [7:0]                target_angle;
        btr_status_t               status;
    } btr_result_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  theta;
        btr_status_t status;
    } btr_ctrl_t;

    typedef logic [63:0] btr_tab91_t [0:90];
    typedef logic [63:0] btr_tab181_t [0:180];

    // Restoring shift-and-subtract division used only to build the tables.
    function automatic logic [63:0] btr_udiv(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sine of whole degrees 0..90 in Q30 by an eleven-term Taylor series.
    function automatic btr_tab91_t btr_sin_q30_table();
        btr_tab91_t  t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        int          k;
        int          n;
        for (k = 0; k <= 90; k++)
        begin
            x    = (64'(k) * BTR_PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 10; n++)
            begin
                term = (term * x2) >> 30;
                term = btr_udiv(term, 64'((2 * n) * (2 * n + 1)));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            t[k] = (sum > 0) ? 64'(sum) : 64'd0;
        end
        return t;
    endfunction

    function automatic btr_tab181_t btr_sin_table(int tfb);
        btr_tab91_t  q;
        btr_tab181_t t;
        logic [63:0] s;
        int          k;
        q = btr_sin_q30_table();
        for (k = 0; k <= 180; k++)
        begin
            s    = q[(k <= 90) ? k : 180 - k];
            t[k] = (s + (64'd1 << (29 - tfb))) >> (30 - tfb);
        end
        return t;
    endfunction

    function automatic btr_tab181_t btr_csc_table(int tfb);
        btr_tab91_t  q;
        btr_tab181_t t;
        logic [63:0] s;
        int          k;
        q = btr_sin_q30_table();
        for (k = 0; k <= 180; k++)
        begin
            s    = q[(k <= 90) ? k : 180 - k];
            t[k] = (s != 64'd0) ? btr_udiv((64'd1 << (tfb + 30)) + (s >> 1), s) : 64'd0;
        end
        return t;
    endfunction

    function automatic btr_tab91_t btr_cot_table(int tfb);
        btr_tab91_t  q;
        btr_tab91_t  t;
        logic [63:0] s;
        int          k;
        q = btr_sin_q30_table();
        for (k = 0; k <= 90; k++)
        begin
            s    = q[k];
            t[k] = (s != 64'd0) ? btr_udiv((q[90 - k] << tfb) + (s >> 1), s) : 64'd0;
        end
        return t;
    endfunction

endpackage

>>> design/btr_geometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bearing triangulation geometry stages
// Normalizes bearings, forms the parallax and interior angles, classifies the
// transaction and looks up the sine, cosecant and cotangent operands.
// ----------------------------------------------------------------------------
module btr_geometry import btr_pkg::*; #(
    parameter int TABLE_FRAC_BITS = BTR_TABLE_FRAC_BITS,
    localparam int SW = TABLE_FRAC_BITS + 1,
    localparam int MW = TABLE_FRAC_BITS + 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  btr_request_t             request,
    output btr_ctrl_t                ctrl,
    output logic                     full,
    output logic [BTR_DIST_BITS-1:0] base,
    output logic [SW-1:0]            sin_first,
    output logic [SW-1:0]            sin_second,
    output logic [MW-1:0]            mult
);

    localparam btr_tab181_t SIN_TAB = btr_sin_table(TABLE_FRAC_BITS);
    localparam btr_tab181_t CSC_TAB = btr_csc_table(TABLE_FRAC_BITS);
    localparam btr_tab91_t  COT_TAB = btr_cot_table(TABLE_FRAC_BITS);

    function automatic logic [8:0] norm_bearing(logic [8:0] b);
        logic [8:0] r;
        r = b;
        if (b == 9'd0)
        begin
            r = 9'd360;
        end
        else if (b > 9'd360)
        begin
            r = b - 9'd360;
        end
        return r;
    endfunction

    function automatic logic [7:0] circ_diff(logic [8:0] a, logic [8:0] b);
        logic [8:0] d;
        d = (a > b) ? (a - b) : (b - a);
        if (d > 9'd180)
        begin
            d = 9'd360 - d;
        end
        return d[7:0];
    endfunction

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_full_reg;
    logic [7:0]               s1_theta_reg;
    logic [7:0]               s1_a1_reg;
    logic [BTR_DIST_BITS-1:0] s1_base_reg;
    logic [7:0]               s1_theta_next;
    logic [7:0]               s1_a1_next;

    btr_ctrl_t                ctrl_reg;
    btr_ctrl_t                ctrl_next;
    logic                     full_reg;
    logic [BTR_DIST_BITS-1:0] base_reg;
    logic [SW-1:0]            sin_first_reg;
    logic [SW-1:0]            sin_first_next;
    logic [SW-1:0]            sin_second_reg;
    logic [SW-1:0]            sin_second_next;
    logic [MW-1:0]            mult_reg;
    logic [MW-1:0]            mult_next;

    logic [8:0]               angle_sum;
    logic [7:0]               a2_idx;
    logic [6:0]               cot_idx;

    always_comb
    begin
        logic [8:0] b1;
        logic [8:0] b2;
        logic [8:0] bb;
        b1            = norm_bearing(request.bearing_one);
        b2            = norm_bearing(request.bearing_two);
        bb            = norm_bearing(request.baseline_bearing);
        s1_valid_next = start;
        s1_theta_next = circ_diff(b1, b2);
        s1_a1_next    = circ_diff(bb, b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_full_reg  <= request.cmd;
        s1_theta_reg <= s1_theta_next;
        s1_a1_reg    <= s1_a1_next;
        s1_base_reg  <= request.baseline_distance;
    end

    always_comb
    begin
        angle_sum        = {1'b0, s1_theta_reg} + {1'b0, s1_a1_reg};
        a2_idx           = (angle_sum < 9'd180) ? 8'(9'd180 - angle_sum) : 8'd0;
        cot_idx          = (s1_theta_reg < 8'd90) ? s1_theta_reg[6:0] : 7'd0;
        ctrl_next.valid  = s1_valid_reg;
        ctrl_next.theta  = s1_theta_reg;
        ctrl_next.status = BTR_OK;
        if (s1_theta_reg == 8'd0)
        begin
            ctrl_next.status = BTR_SAME;
        end
        else if (!s1_full_reg)
        begin
            if (s1_theta_reg >= 8'd90)
            begin
                ctrl_next.status = BTR_WIDE;
            end
        end
        else if (s1_a1_reg == 8'd0 || angle_sum >= 9'd180 || s1_base_reg == '0)
        begin
            ctrl_next.status = BTR_GEOM;
        end
        sin_first_next  = SIN_TAB[a2_idx][SW-1:0];
        sin_second_next = SIN_TAB[s1_a1_reg][SW-1:0];
        mult_next       = s1_full_reg ? CSC_TAB[s1_theta_reg][MW-1:0]
                                      : COT_TAB[cot_idx][MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        full_reg       <= s1_full_reg;
        base_reg       <= s1_base_reg;
        sin_first_reg  <= sin_first_next;
        sin_second_reg <= sin_second_next;
        mult_reg       <= mult_next;
    end

    assign ctrl       = ctrl_reg;
    assign full       = full_reg;
    assign base       = base_reg;
    assign sin_first  = sin_first_reg;
    assign sin_second = sin_second_reg;
    assign mult       = mult_reg;

endmodule

>>> design/btr_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bearing triangulation range scaler
// Three-stage product of baseline and sine with cosecant, or of baseline and
// cotangent, with round-to-nearest and saturation to the range field.
// ----------------------------------------------------------------------------
module btr_scaler import btr_pkg::*; #(
    parameter int FRAC_BITS       = BTR_FRAC_BITS,
    parameter int TABLE_FRAC_BITS = BTR_TABLE_FRAC_BITS,
    localparam int SW = TABLE_FRAC_BITS + 1,
    localparam int MW = TABLE_FRAC_BITS + 6
) (
    input  logic                      clk,
    input  logic                      full,
    input  logic [BTR_DIST_BITS-1:0]  base,
    input  logic [SW-1:0]             sin_val,
    input  logic [MW-1:0]             mult,
    output logic [BTR_RANGE_BITS-1:0] range_val
);

    localparam int PW  = BTR_DIST_BITS + TABLE_FRAC_BITS + 1;
    localparam int HW  = (PW + 1) / 2;
    localparam int HIW = PW - HW;
    localparam int PRW = PW + MW;
    localparam int SH  = 2 * TABLE_FRAC_BITS - FRAC_BITS;
    localparam int QW  = ((PRW + 1 - SH) > (BTR_RANGE_BITS + 1)) ? (PRW + 1 - SH)
                                                                 : (BTR_RANGE_BITS + 1);
    localparam logic [PRW:0] RND = (PRW + 1)'(1) << (SH - 1);

    logic [PW-1:0]             p1_reg;
    logic [PW-1:0]             p1_next;
    logic [MW-1:0]             m_reg;
    logic [HW+MW-1:0]          lo_reg;
    logic [HW+MW-1:0]          lo_next;
    logic [HIW+MW-1:0]         hi_reg;
    logic [HIW+MW-1:0]         hi_next;
    logic [BTR_RANGE_BITS-1:0] range_reg;
    logic [BTR_RANGE_BITS-1:0] range_next;
    logic [PRW:0]              total;
    logic [QW-1:0]             quot;

    always_comb
    begin
        if (full)
        begin
            p1_next = PW'(base) * PW'(sin_val);
        end
        else
        begin
            p1_next = PW'({base, {TABLE_FRAC_BITS{1'b0}}});
        end
        lo_next    = (HW + MW)'(p1_reg[HW-1:0]) * (HW + MW)'(m_reg);
        hi_next    = (HIW + MW)'(p1_reg[PW-1:HW]) * (HIW + MW)'(m_reg);
        total      = ((PRW + 1)'(hi_reg) << HW) + (PRW + 1)'(lo_reg) + RND;
        quot       = QW'(total >> SH);
        range_next = (|quot[QW-1:BTR_RANGE_BITS]) ? '1 : quot[BTR_RANGE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p1_next;
        m_reg     <= mult;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        range_reg <= range_next;
    end

    assign range_val = range_reg;

endmodule

>>> design/bearing_triangulation_ranger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bearing triangulation ranger
// Ranges to a target from two bearings and a baseline, by cotangent estimate
// or by the law of sines, in unsigned fixed point with rounding.
//
//   Channel   Handshake           Payload          Direction
//   request   start / busy        btr_request_t    in
//   result    done (one cycle)    btr_result_t     out
//
// One transaction is taken every cycle; busy is held low.
// The pipeline has two stages of angle logic and table lookup, then
// three stages of the multiply, round and saturate datapath.
// Reset clears the control registers of the pipeline only; the tables are constants.
// The receiver cannot stall, so results leave on the cycle they are ready.
// ----------------------------------------------------------------------------
module bearing_triangulation_ranger_unit import btr_pkg::*; #(
    parameter int FRAC_BITS       = BTR_FRAC_BITS,
    parameter int TABLE_FRAC_BITS = BTR_TABLE_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  btr_request_t request,
    output logic         done,
    output btr_result_t  result
);

    localparam int SW = TABLE_FRAC_BITS + 1;
    localparam int MW = TABLE_FRAC_BITS + 6;

    btr_ctrl_t                 geo_ctrl;
    logic                      geo_full;
    logic [BTR_DIST_BITS-1:0]  geo_base;
    logic [SW-1:0]             geo_sin_first;
    logic [SW-1:0]             geo_sin_second;
    logic [MW-1:0]             geo_mult;
    logic [BTR_RANGE_BITS-1:0] range_first;
    logic [BTR_RANGE_BITS-1:0] range_second;

    btr_ctrl_t                 s3_ctrl_reg;
    btr_ctrl_t                 s4_ctrl_reg;
    btr_ctrl_t                 s5_ctrl_reg;
    logic                      ok;

    btr_geometry #(
        .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
    ) u_geometry (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start && !busy),
        .request    (request),
        .ctrl       (geo_ctrl),
        .full       (geo_full),
        .base       (geo_base),
        .sin_first  (geo_sin_first),
        .sin_second (geo_sin_second),
        .mult       (geo_mult)
    );

    btr_scaler #(
        .FRAC_BITS       (FRAC_BITS),
        .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
    ) u_scaler_first (
        .clk       (clk),
        .full      (geo_full),
        .base      (geo_base),
        .sin_val   (geo_sin_first),
        .mult      (geo_mult),
        .range_val (range_first)
    );

    btr_scaler #(
        .FRAC_BITS       (FRAC_BITS),
        .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
    ) u_scaler_second (
        .clk       (clk),
        .full      (geo_full),
        .base      (geo_base),
        .sin_val   (geo_sin_second),
        .mult      (geo_mult),
        .range_val (range_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
            s5_ctrl_reg <= '0;
        end
        else
        begin
            s3_ctrl_reg <= geo_ctrl;
            s4_ctrl_reg <= s3_ctrl_reg;
            s5_ctrl_reg <= s4_ctrl_reg;
        end
    end

    assign busy = 1'b0;
    assign done = s5_ctrl_reg.valid;
    assign ok   = (s5_ctrl_reg.status == BTR_OK);

    always_comb
    begin
        result.range_from_first  = ok ? range_first : '0;
        result.range_from_second = ok ? range_second : '0;
        result.target_angle      = s5_ctrl_reg.theta;
        result.status            = s5_ctrl_reg.status;
    end

endmodule
